// ===== hdl/sector_pattern_run_decoder_assert.svh =====
// Assertion macros for the sector pattern run decoder checker.
// Every property is clocked on i_clk and disabled while i_rst_n is low.
`ifndef SECTOR_PATTERN_RUN_DECODER_ASSERT_SVH
`define SECTOR_PATTERN_RUN_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SPRD_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPRD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sprd_pkg.sv =====
// Shared constants and types of the sector pattern run decoder.
// Used by the top level and by its port checker; depends on nothing.
package sprd_pkg;

    localparam int SECTOR_BYTES_MAX  = 16384;
    localparam int PATTERN_BYTES_MAX = 512;
    localparam int SEC_AW   = $clog2(SECTOR_BYTES_MAX);
    localparam int POS_W    = SEC_AW + 1;
    localparam int PAT_AW   = $clog2(PATTERN_BYTES_MAX);
    localparam int RUN_W    = 9;
    localparam int REP_W    = 16;
    localparam int CODE_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int BASE_LEN = 128;

    localparam logic [PADDR_W-1:0] ADDR_SIZE_CODE = '0;
    localparam logic [CODE_W-1:0]  CODE_RESET     = 3'd1;

    localparam logic [7:0] BYTE_COPY    = 8'd0;
    localparam logic [7:0] BYTE_REPEAT  = 8'd1;
    localparam logic [7:0] BYTE_RECORDS = 8'd2;
    localparam logic [7:0] BYTE_LITERAL = 8'd0;

    typedef enum logic [2:0] {
        PH_IDLE, PH_COPY, PH_CNT_LO, PH_CNT_HI,
        PH_PATTERN, PH_SUB, PH_LITCNT, PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        M_COPY, M_REPEAT, M_RECORDS, M_UNKNOWN
    } t_method;

    function automatic logic [POS_W-1:0] sector_len(input logic [CODE_W-1:0] code);
        sector_len = POS_W'(BASE_LEN) << code;
    endfunction

endpackage

// ===== hdl/sector_pattern_run_decoder.sv =====
// Sector pattern run decoder: parses encoded sector bytes into a sector store
// and serves byte reads from it. Depends on sprd_pkg.
// A request passes from S_IDLE through S_DONE into the result registers; a request that closes
// a pattern first passes through S_EXP, one pattern RAM read per byte written.
// No new request is taken before the last one is back in S_IDLE. Reset clears control state
// and sets the size code to 1; the sector and pattern stores are not cleared and hold garbage
// until written.
module sector_pattern_run_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sprd_pkg::PADDR_W-1:0]      paddr,
    input  logic [sprd_pkg::PDATA_W-1:0]      pwdata,
    output logic [sprd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_block_start,
    input  logic [sprd_pkg::SEC_AW-1:0]       i_read_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [7:0]                        o_read_data,
    output logic [sprd_pkg::POS_W-1:0]        o_fill_position,
    output logic                              o_sector_full,
    output logic                              o_status
);
    import sprd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXP, S_DONE} t_state;

    logic [7:0] sec_mem [SECTOR_BYTES_MAX];
    logic [7:0] pat_mem [PATTERN_BYTES_MAX];

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    t_method             r_method, n_method;
    logic [RUN_W-1:0]    r_rl, n_rl;
    logic [REP_W-1:0]    r_rc, n_rc;
    logic [PAT_AW-1:0]   r_pf, n_pf;
    logic [POS_W-1:0]    r_wp, n_wp;
    logic [RUN_W-1:0]    r_k, n_k;
    logic [REP_W-1:0]    r_rep, n_rep;
    logic                r_pend, n_pend;
    logic [SEC_AW-1:0]   r_pend_addr, n_pend_addr;
    logic                r_is_read, n_is_read;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_rd, n_rd;
    logic [POS_W-1:0]    r_fill, n_fill;
    logic                r_full, n_full;
    logic                r_status, n_status;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [7:0]          r_sec_rd, r_pat_rd;

    logic                accept, cfg_we, wp_full, sec_we, sec_re, pat_we, pat_re;
    logic [SEC_AW-1:0]   sec_waddr;
    logic [7:0]          sec_wdata;
    logic [POS_W-1:0]    len, wp_step;
    logic [RUN_W-1:0]    rl_dec;
    logic [PAT_AW-1:0]   pf_inc;
    t_phase              ph_after;

    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_SIZE_CODE) ? PDATA_W'(r_code) : '0;
    assign cfg_we      = psel && penable && pwrite && (paddr == ADDR_SIZE_CODE);
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign len         = sector_len(r_code);
    assign wp_full     = (r_wp >= len);
    assign ph_after    = (r_method == M_RECORDS && !wp_full) ? PH_SUB : PH_SKIP;
    assign wp_step     = wp_full ? r_wp : r_wp + POS_W'(1);
    assign rl_dec      = (r_rl != '0) ? r_rl - RUN_W'(1) : '0;
    assign pf_inc      = r_pf + PAT_AW'(1);

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_rd;
    assign o_fill_position = r_fill;
    assign o_sector_full   = r_full;
    assign o_status        = r_status;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_method    = r_method;
        n_rl        = r_rl;
        n_rc        = r_rc;
        n_pf        = r_pf;
        n_wp        = r_wp;
        n_k         = r_k;
        n_rep       = r_rep;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_is_read   = r_is_read;
        n_out_valid = r_out_valid && i_out_stall;
        n_rd        = r_rd;
        n_fill      = r_fill;
        n_full      = r_full;
        n_status    = r_status;
        n_code      = cfg_we ? pwdata[CODE_W-1:0] : r_code;
        // the delayed pattern write lands in the cycle after its read
        sec_we      = r_pend;
        sec_waddr   = r_pend_addr;
        sec_wdata   = r_pat_rd;
        sec_re      = 1'b0;
        pat_we      = 1'b0;
        pat_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_read = i_mode;
                    n_state   = S_DONE;
                    if (i_mode) begin
                        sec_re = 1'b1;
                    end else if (i_block_start) begin
                        n_wp = '0;
                        n_rl = '0;
                        n_rc = '0;
                        n_pf = '0;
                        if (i_data_byte == BYTE_COPY) begin
                            n_method = M_COPY;
                            n_phase  = PH_COPY;
                        end else if (i_data_byte == BYTE_REPEAT) begin
                            n_method = M_REPEAT;
                            n_rl     = RUN_W'(2);
                            n_phase  = PH_CNT_LO;
                        end else if (i_data_byte == BYTE_RECORDS) begin
                            n_method = M_RECORDS;
                            n_phase  = PH_SUB;
                        end else begin
                            n_method = M_UNKNOWN;
                            n_phase  = PH_SKIP;
                        end
                    end else begin
                        case (r_phase)
                            PH_COPY: begin
                                if (!wp_full) begin
                                    sec_we    = 1'b1;
                                    sec_waddr = r_wp[SEC_AW-1:0];
                                    sec_wdata = i_data_byte;
                                end
                                n_wp = wp_step;
                                if (wp_step >= len) begin
                                    n_phase = PH_SKIP;
                                end else if (r_method == M_RECORDS) begin
                                    n_rl = rl_dec;
                                    if (rl_dec == '0) n_phase = PH_SUB;
                                end
                            end
                            PH_CNT_LO: begin
                                n_rc    = REP_W'(i_data_byte);
                                n_pf    = '0;
                                n_phase = (r_method == M_REPEAT) ? PH_CNT_HI : PH_PATTERN;
                            end
                            PH_CNT_HI: begin
                                n_rc    = {i_data_byte, r_rc[7:0]};
                                n_phase = PH_PATTERN;
                            end
                            PH_PATTERN: begin
                                pat_we = 1'b1;
                                n_pf   = pf_inc;
                                if (RUN_W'(pf_inc) >= r_rl) begin
                                    n_k     = '0;
                                    n_rep   = r_rc;
                                    n_state = S_EXP;
                                end
                            end
                            PH_SUB: begin
                                if (i_data_byte == BYTE_LITERAL) begin
                                    n_phase = PH_LITCNT;
                                end else begin
                                    n_rl    = {i_data_byte, 1'b0};
                                    n_phase = PH_CNT_LO;
                                end
                            end
                            PH_LITCNT: begin
                                n_rl = RUN_W'(i_data_byte);
                                n_phase = (i_data_byte == BYTE_LITERAL) ? ph_after : PH_COPY;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_EXP: begin
                // issue one pattern read per cycle; the write follows next cycle
                if (r_rep != '0 && !wp_full) begin
                    pat_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_wp[SEC_AW-1:0];
                    n_wp        = r_wp + POS_W'(1);
                    if (r_k + RUN_W'(1) == r_rl) begin
                        n_k   = '0;
                        n_rep = r_rep - REP_W'(1);
                    end else begin
                        n_k = r_k + RUN_W'(1);
                    end
                end else begin
                    n_phase = ph_after;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result stage is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_rd        = r_is_read ? r_sec_rd : 8'd0;
                    n_fill      = r_wp;
                    n_full      = wp_full;
                    n_status    = (r_method == M_UNKNOWN);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_method    <= M_COPY;
            r_rl        <= '0;
            r_rc        <= '0;
            r_pf        <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_rep       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_code      <= CODE_RESET;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_method    <= n_method;
            r_rl        <= n_rl;
            r_rc        <= n_rc;
            r_pf        <= n_pf;
            r_wp        <= n_wp;
            r_k         <= n_k;
            r_rep       <= n_rep;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
            r_pend_addr <= n_pend_addr;
            r_is_read   <= n_is_read;
            r_rd        <= n_rd;
            r_fill      <= n_fill;
            r_full      <= n_full;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sec_we) sec_mem[sec_waddr] <= sec_wdata;
        if (sec_re) r_sec_rd <= sec_mem[i_read_address];
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) pat_mem[r_pf] <= i_data_byte;
        if (pat_re) r_pat_rd <= pat_mem[r_k[PAT_AW-1:0]];
    end

endmodule

// ===== hdl/sprd_checker.sv =====
// Port-level checker for the sector pattern run decoder, bound to the top.
// Depends on sprd_pkg and sector_pattern_run_decoder_assert.svh.
`include "sector_pattern_run_decoder_assert.svh"

module sprd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [7:0]                  o_read_data,
    input logic [sprd_pkg::POS_W-1:0]  o_fill_position,
    input logic                        o_sector_full,
    input logic                        o_status
);
    import sprd_pkg::*;

    // a stalled result holds
    `SPRD_CHECK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_fill_position), "stalled result changed")
    // fill never passes the largest sector
    `SPRD_CHECK_IMP(a_fill_cap, o_out_valid, o_fill_position <= POS_W'(SECTOR_BYTES_MAX), "fill position beyond store")
    // a full sector holds at least the smallest sector length
    `SPRD_CHECK_IMP(a_full_fill, o_out_valid && o_sector_full, o_fill_position >= POS_W'(BASE_LEN), "sector full with short fill")
    // an unknown method writes nothing
    `SPRD_CHECK_IMP(a_unknown_empty, o_out_valid && o_status, o_fill_position == '0, "unknown method wrote bytes")

endmodule

bind sector_pattern_run_decoder sprd_checker u_sprd_checker (.*);
